>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LOBM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LOBM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lobm_pkg.sv
// Package: order book codes, widths and control types.
`default_nettype none
package lobm_pkg;
   localparam int unsigned LEVEL_DEPTH_DEF = 16;
   localparam int unsigned PRICE_BITS_DEF  = 32;
   localparam int unsigned VOL_BITS        = 24;
   localparam int unsigned ACTION_BITS     = 2;
   localparam int unsigned STATUS_BITS     = 2;

   localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_CANCEL = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_MATCH  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd3;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_MATCH = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE    = 2'd3;

   typedef struct packed {
      logic ins;   // insert new level in sorted position
      logic rem;   // remove level at rem_idx, shift toward best
      logic upd;   // overwrite best level volume
      logic clr;   // drop all levels
   } lobm_ctl_type;
endpackage
`default_nettype wire

>>> hdl/lobm_if.sv
// Request and response channel interfaces.
`default_nettype none
interface lobm_req_if
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF
) ();
   localparam int unsigned IW = $clog2(LEVEL_DEPTH);

   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic                   side;
   logic [PRICE_BITS-1:0]  price;
   logic [VOL_BITS-1:0]    volume;
   logic [IW-1:0]          index;

   modport source (output valid, action, side, price, volume, index, input ready);
   modport sink   (input valid, action, side, price, volume, index, output ready);
endinterface

interface lobm_rsp_if
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF
) ();
   localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [PRICE_BITS-1:0]  fill_price;
   logic [VOL_BITS-1:0]    fill_volume;
   logic [VOL_BITS-1:0]    remaining_volume;
   logic                   order_filled;
   logic [PRICE_BITS-1:0]  best_bid;
   logic [PRICE_BITS-1:0]  best_ask;
   logic [CW-1:0]          bid_levels;
   logic [CW-1:0]          ask_levels;

   modport source (output valid, status, fill_price, fill_volume, remaining_volume,
                    order_filled, best_bid, best_ask, bid_levels, ask_levels,
                   input ready);
   modport sink   (input valid, status, fill_price, fill_volume, remaining_volume,
                   order_filled, best_bid, best_ask, bid_levels, ask_levels,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/limit_order_book_top_match.sv
// Top level: price-level order book with top-of-book matching.
//
//  channel    dir  handshake               carries
//  req_chan   in   valid/ready             action, side, price, volume, index
//  rsp_chan   out  valid/ready             status, fill data, best prices, level counts
//
//  One transaction per cycle unless stalled; response valid the cycle after acceptance.
//  All cells of a side insert or shift at once; one price compare per cell.
//  req_chan.ready is low while a response waits and rsp_chan.ready is low.
//  Best prices and level counts on rsp_chan come straight from the level registers.
//  Reset clears both level counts and the response valid; no clearing pass.
`default_nettype none
module limit_order_book_top_match
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   lobm_req_if.sink    req_chan,
   lobm_rsp_if.source  rsp_chan
);
   localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
   localparam int unsigned IW = $clog2(LEVEL_DEPTH);

   lobm_ctl_type          bid_ctl, ask_ctl, own_ctl, opp_ctl;
   logic [CW-1:0]         bid_cnt, ask_cnt, own_cnt, opp_cnt;
   logic                  bid_full, ask_full, own_full;
   logic [PRICE_BITS-1:0] bid_best, ask_best, opp_best;
   logic [VOL_BITS-1:0]   bid_bvol, ask_bvol, opp_bvol;
   logic [VOL_BITS-1:0]   fvol, lvl_left, ord_left, side_vol;
   logic [IW-1:0]         side_idx;
   logic                  acc, crosses;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [PRICE_BITS-1:0]  fprice_ff, fprice_in;
   logic [VOL_BITS-1:0]    fvol_ff, fvol_in;
   logic [VOL_BITS-1:0]    rem_ff, rem_in;
   logic                   filled_ff, filled_in;

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign acc            = req_chan.valid && req_chan.ready;

   assign own_cnt  = req_chan.side ? ask_cnt  : bid_cnt;
   assign own_full = req_chan.side ? ask_full : bid_full;
   assign opp_cnt  = req_chan.side ? bid_cnt  : ask_cnt;
   assign opp_best = req_chan.side ? bid_best : ask_best;
   assign opp_bvol = req_chan.side ? bid_bvol : ask_bvol;

   assign crosses = (opp_cnt != '0) &&
                    (req_chan.side ? (req_chan.price <= opp_best)
                                   : (req_chan.price >= opp_best));
   assign fvol     = (req_chan.volume < opp_bvol) ? req_chan.volume : opp_bvol;
   assign lvl_left = opp_bvol - fvol;
   assign ord_left = req_chan.volume - fvol;

   assign side_vol = (req_chan.action == ACT_MATCH) ? lvl_left : req_chan.volume;
   assign side_idx = (req_chan.action == ACT_CANCEL) ? req_chan.index : '0;

   always_comb begin
      own_ctl   = '0;
      opp_ctl   = '0;
      status_in = ST_DONE;
      fprice_in = '0;
      fvol_in   = '0;
      rem_in    = '0;
      filled_in = 1'b0;
      unique case (req_chan.action)
         ACT_ADD: begin
            if (own_full) begin
               status_in = ST_FULL;
            end else begin
               own_ctl.ins = acc;
            end
         end
         ACT_CANCEL: begin
            if (CW'(req_chan.index) >= own_cnt) begin
               status_in = ST_RANGE;
            end else begin
               own_ctl.rem = acc;
            end
         end
         ACT_MATCH: begin
            if (crosses) begin
               fprice_in = opp_best;
               fvol_in   = fvol;
               rem_in    = ord_left;
               filled_in = ord_left == '0;
               if (lvl_left == '0) begin
                  opp_ctl.rem = acc;
               end else begin
                  opp_ctl.upd = acc;
               end
            end else begin
               status_in = ST_NO_MATCH;
               rem_in    = req_chan.volume;
            end
         end
         ACT_CLEAR: begin
            own_ctl.clr = acc;
            opp_ctl.clr = acc;
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   assign bid_ctl = (req_chan.side == SIDE_BID) ? own_ctl : opp_ctl;
   assign ask_ctl = (req_chan.side == SIDE_ASK) ? own_ctl : opp_ctl;

   lobm_side #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .PRICE_BITS  (PRICE_BITS),
      .DESC        (1'b1)
   ) u_bids (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bid_ctl),
      .rem_idx    (side_idx),
      .new_price  (req_chan.price),
      .new_vol    (side_vol),
      .count      (bid_cnt),
      .full       (bid_full),
      .best_price (bid_best),
      .best_vol   (bid_bvol)
   );

   lobm_side #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .PRICE_BITS  (PRICE_BITS),
      .DESC        (1'b0)
   ) u_asks (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ask_ctl),
      .rem_idx    (side_idx),
      .new_price  (req_chan.price),
      .new_vol    (side_vol),
      .count      (ask_cnt),
      .full       (ask_full),
      .best_price (ask_best),
      .best_vol   (ask_bvol)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         status_ff <= status_in;
         fprice_ff <= fprice_in;
         fvol_ff   <= fvol_in;
         rem_ff    <= rem_in;
         filled_ff <= filled_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.fill_price       = fprice_ff;
   assign rsp_chan.fill_volume      = fvol_ff;
   assign rsp_chan.remaining_volume = rem_ff;
   assign rsp_chan.order_filled     = filled_ff;
   assign rsp_chan.best_bid         = bid_best;
   assign rsp_chan.best_ask         = ask_best;
   assign rsp_chan.bid_levels       = bid_cnt;
   assign rsp_chan.ask_levels       = ask_cnt;
endmodule
`default_nettype wire

>>> hdl/lobm_cell.sv
// One price level cell of a sorted side table.
`default_nettype none
module lobm_cell
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
   parameter int unsigned IDX         = 0,
   parameter bit          DESC        = 1'b1
) (
   input  wire logic                              clock,
   input  wire lobm_ctl_type                      ctl,
   input  wire logic [$clog2(LEVEL_DEPTH+1)-1:0]  count,
   input  wire logic [$clog2(LEVEL_DEPTH)-1:0]    rem_idx,
   input  wire logic [PRICE_BITS-1:0]             new_price,
   input  wire logic [VOL_BITS-1:0]               new_vol,
   input  wire logic                              left_gb,
   input  wire logic [PRICE_BITS-1:0]             left_price,
   input  wire logic [VOL_BITS-1:0]               left_vol,
   input  wire logic [PRICE_BITS-1:0]             right_price,
   input  wire logic [VOL_BITS-1:0]               right_vol,
   output logic                                   gb,
   output logic [PRICE_BITS-1:0]                  price,
   output logic [VOL_BITS-1:0]                    vol
);
   localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
   localparam int unsigned IW = $clog2(LEVEL_DEPTH);
   localparam logic [CW-1:0] POS_C = CW'(IDX);
   localparam logic [IW-1:0] POS_I = IW'(IDX);

   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [VOL_BITS-1:0]   vol_ff, vol_in;
   logic                  occ, cmp;

   // new level goes at or before this cell
   assign occ = POS_C < count;
   assign cmp = DESC ? (price_ff < new_price) : (price_ff > new_price);
   assign gb  = !occ || cmp;

   always_comb begin
      price_in = price_ff;
      vol_in   = vol_ff;
      priority if (ctl.ins && gb) begin
         if (left_gb) begin
            price_in = left_price;
            vol_in   = left_vol;
         end else begin
            price_in = new_price;
            vol_in   = new_vol;
         end
      end else if (ctl.rem && (POS_I >= rem_idx)) begin
         price_in = right_price;
         vol_in   = right_vol;
      end else if (ctl.upd && (IDX == 0)) begin
         vol_in = new_vol;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      vol_ff   <= vol_in;
   end

   assign price = price_ff;
   assign vol   = vol_ff;
endmodule
`default_nettype wire

>>> hdl/lobm_side.sv
// One side of the book: a row of level cells and the level count.
`default_nettype none
module lobm_side
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
   parameter bit          DESC        = 1'b1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lobm_ctl_type                      ctl,
   input  wire logic [$clog2(LEVEL_DEPTH)-1:0]    rem_idx,
   input  wire logic [PRICE_BITS-1:0]             new_price,
   input  wire logic [VOL_BITS-1:0]               new_vol,
   output logic [$clog2(LEVEL_DEPTH+1)-1:0]       count,
   output logic                                   full,
   output logic [PRICE_BITS-1:0]                  best_price,
   output logic [VOL_BITS-1:0]                    best_vol
);
   localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LEVEL_DEPTH);

   logic [CW-1:0]         count_ff, count_in;
   logic                  gb_w    [LEVEL_DEPTH];
   logic [PRICE_BITS-1:0] price_w [LEVEL_DEPTH];
   logic [VOL_BITS-1:0]   vol_w   [LEVEL_DEPTH];

   for (genvar i = 0; i < LEVEL_DEPTH; i++) begin : g_cell
      logic                  l_gb;
      logic [PRICE_BITS-1:0] l_price, r_price;
      logic [VOL_BITS-1:0]   l_vol, r_vol;

      if (i == 0) begin : g_first
         assign l_gb    = 1'b0;
         assign l_price = '0;
         assign l_vol   = '0;
      end else begin : g_mid
         assign l_gb    = gb_w[i-1];
         assign l_price = price_w[i-1];
         assign l_vol   = vol_w[i-1];
      end

      if (i == LEVEL_DEPTH - 1) begin : g_last
         assign r_price = '0;
         assign r_vol   = '0;
      end else begin : g_inner
         assign r_price = price_w[i+1];
         assign r_vol   = vol_w[i+1];
      end

      lobm_cell #(
         .LEVEL_DEPTH (LEVEL_DEPTH),
         .PRICE_BITS  (PRICE_BITS),
         .IDX         (i),
         .DESC        (DESC)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .rem_idx     (rem_idx),
         .new_price   (new_price),
         .new_vol     (new_vol),
         .left_gb     (l_gb),
         .left_price  (l_price),
         .left_vol    (l_vol),
         .right_price (r_price),
         .right_vol   (r_vol),
         .gb          (gb_w[i]),
         .price       (price_w[i]),
         .vol         (vol_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.clr) begin
         count_in = '0;
      end else if (ctl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign full       = count_ff == DEPTH_C;
   assign best_price = (count_ff != '0) ? price_w[0] : '0;
   assign best_vol   = vol_w[0];
endmodule
`default_nettype wire

>>> hdl/lobm_checker.sv
// Port-level checker for the order book top level, with its bind.
`default_nettype none
`include "assert_macros.svh"
module lobm_checker
   import lobm_pkg::*;
#(
   parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [STATUS_BITS-1:0]            rsp_status,
   input wire logic [VOL_BITS-1:0]               rsp_fill_volume,
   input wire logic [PRICE_BITS-1:0]             rsp_best_bid,
   input wire logic [$clog2(LEVEL_DEPTH+1)-1:0]  rsp_bid_levels,
   input wire logic [$clog2(LEVEL_DEPTH+1)-1:0]  rsp_ask_levels
);
   localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LEVEL_DEPTH);

   `LOBM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                    "response dropped while stalled")
   `LOBM_ASSERT_NXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid,
                    "no response after accepted transaction")
   `LOBM_ASSERT_IMP(a_levels_max, clock, reset, 1'b1,
                    (rsp_bid_levels <= DEPTH_C) && (rsp_ask_levels <= DEPTH_C),
                    "level count above depth")
   `LOBM_ASSERT_IMP(a_empty_bid, clock, reset, rsp_bid_levels == '0, rsp_best_bid == '0,
                    "best bid nonzero on empty side")
   `LOBM_ASSERT_IMP(a_fill_status, clock, reset, rsp_valid && (rsp_status != ST_DONE),
                    rsp_fill_volume == '0, "fill volume on a failed transaction")
endmodule

bind limit_order_book_top_match lobm_checker #(
   .LEVEL_DEPTH (LEVEL_DEPTH),
   .PRICE_BITS  (PRICE_BITS)
) u_lobm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_fill_volume (rsp_chan.fill_volume),
   .rsp_best_bid    (rsp_chan.best_bid),
   .rsp_bid_levels  (rsp_chan.bid_levels),
   .rsp_ask_levels  (rsp_chan.ask_levels)
);
`default_nettype wire
